### hw/rtl/lafp_pkg.sv
// shared types and constants for the lifetime aware first fit placer
`default_nettype none
package lafp_pkg;
  localparam int unsigned MaxBuffersDef = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SizeW = 32;
  localparam int unsigned OffW  = 38;

  typedef struct packed {
    logic             new_frame;
    logic [TimeW-1:0] life_start;
    logic [TimeW-1:0] life_end;
    logic [SizeW-1:0] alloc_size;
  } in_t;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [OffW-1:0] peak;
    logic            table_full;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0] life_start;
    logic [TimeW-1:0] life_end;
    logic [OffW-1:0]  lo;
    logic [OffW-1:0]  hi;
  } entry_t;
endpackage
`default_nettype wire

### hw/rtl/lifetime_aware_first_fit_placer_unit.sv
// top level of the lifetime aware first fit placer
//
// channel  | direction | handshake                 | payload
// command  | in        | start high, busy low      | item_i (in_t)
// result   | out       | result_valid_o one cycle  | result_o (out_t)
//
// one transaction runs passes over the placed table, a read step and a check
// step per entry; a pass repeats while the candidate offset moved, so busy stays
// high through the passes, at most n+1 of them, n = placed buffers.
// a full table answers without raising busy, the result the next cycle.
// the registered table ram read port is why each entry needs its own read step. reset clears count, peak and fsm.
// the receiver cannot stall; the result shows for one cycle after busy drops.
`default_nettype none
module lifetime_aware_first_fit_placer_unit #(
  parameter int unsigned MaxBuffers = lafp_pkg::MaxBuffersDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire lafp_pkg::in_t  item_i,
  output logic                busy,
  output lafp_pkg::out_t      result_o,
  output logic                result_valid_o
);
  import lafp_pkg::*;

  localparam int unsigned AW = (MaxBuffers > 1) ? $clog2(MaxBuffers) : 1;
  localparam int unsigned CW = $clog2(MaxBuffers + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxBuffers);
  localparam logic [CW-1:0] CntOne = CW'(1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [OffW-1:0] peak_q, peak_d;
  logic [OffW-1:0] x_q, x_d;
  logic [OffW:0]   xs_q, xs_d;
  logic            moved_q, moved_d;
  in_t             item_q, item_d;
  out_t            res_q, res_d;
  logic            done_q, done_d;

  entry_t          rd_entry, wr_entry;
  logic            we;
  logic [OffW:0]   top;
  logic            live_new, live_old, overlap, conflict;

  lafp_ram #(.Width($bits(entry_t)), .Depth(MaxBuffers)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  assign top = {1'b0, x_q} + {{(OffW+1-SizeW){1'b0}}, item_q.alloc_size};
  assign wr_entry = '{life_start: item_q.life_start, life_end: item_q.life_end,
                      lo: x_q, hi: top[OffW-1:0]};

  always_comb begin
    live_new = item_q.life_end > item_q.life_start;
    live_old = rd_entry.life_end > rd_entry.life_start;
    overlap  = live_new && live_old && (item_q.life_start < rd_entry.life_end) &&
               (rd_entry.life_start < item_q.life_end);
    conflict = overlap && ({1'b0, rd_entry.lo} < xs_q) && (rd_entry.hi > x_q);
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    peak_d  = peak_q;
    x_d     = x_q;
    xs_d    = xs_q;
    moved_d = moved_q;
    item_d  = item_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we      = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          item_d  = item_i;
          x_d     = '0;
          idx_d   = '0;
          moved_d = 1'b0;
          if (item_i.new_frame) begin
            count_d = '0;
            peak_d  = '0;
          end
          if (!item_i.new_frame && count_q >= CntMax) begin
            res_d   = '{offset: '0, peak: peak_q, table_full: 1'b1};
            done_d  = 1'b1;
          end else if (item_i.new_frame || count_q == '0) begin
            state_d = StFin;
          end else begin
            state_d = StRd;
          end
        end
      end
      StRd: begin
        xs_d    = {1'b0, x_q} + {{(OffW+1-SizeW){1'b0}}, item_q.alloc_size};
        state_d = StChk;
      end
      StChk: begin
        if (conflict) begin
          x_d     = rd_entry.hi;
          moved_d = 1'b1;
        end
        if (idx_q + CntOne == count_q) begin
          idx_d = '0;
          if (moved_q || conflict) begin
            moved_d = 1'b0;
            state_d = StRd;
          end else begin
            state_d = StFin;
          end
        end else begin
          idx_d   = idx_q + CntOne;
          state_d = StRd;
        end
      end
      StFin: begin
        we      = 1'b1;
        count_d = count_q + CntOne;
        if (top[OffW-1:0] > peak_q) begin
          peak_d = top[OffW-1:0];
        end
        res_d   = '{offset: x_q, peak: peak_d, table_full: 1'b0};
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      peak_q  <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      moved_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      moved_q <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    xs_q   <= xs_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_o       = res_q;
  assign result_valid_o = done_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("placed count beyond capacity");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.table_full |-> result_o.offset == '0)
    else $error("full result with nonzero offset");
  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.table_full |-> result_o.peak >= result_o.offset)
    else $error("peak below offset");
  a_fin_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin |=> result_valid_o && !busy)
    else $error("placement finished without result");
endmodule
`default_nettype wire

### hw/rtl/lafp_ram.sv
// generic single write port ram with registered read
`default_nettype none
module lafp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### tb/lifetime_aware_first_fit_placer_unit_tb.sv
// testbench for the lifetime aware first fit placer: directed and random placements
`default_nettype none
module lifetime_aware_first_fit_placer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lafp_pkg::*;

  localparam int unsigned Depth = MaxBuffersDef;
  localparam int unsigned WatchLimit = 200000;

  class placement_board;
    logic [TimeW-1:0] tab_start [Depth];
    logic [TimeW-1:0] tab_end [Depth];
    logic [OffW-1:0]  tab_off [Depth];
    logic [SizeW-1:0] tab_size [Depth];
    int unsigned      count;
    logic [OffW-1:0]  frame_peak;
    out_t             pending[$];
    int unsigned      errors;

    function void clear_table();
      count = 0;
      frame_peak = '0;
    endfunction

    function logic [OffW-1:0] first_fit(logic [TimeW-1:0] s, logic [TimeW-1:0] e,
                                        logic [SizeW-1:0] sz);
      logic [OffW-1:0] lo_q[$];
      logic [OffW-1:0] hi_q[$];
      logic [OffW-1:0] lo;
      logic [OffW-1:0] hi;
      logic [OffW-1:0] cand;
      int k;
      cand = '0;
      for (int i = 0; i < count; i++) begin
        if (e > s && tab_end[i] > tab_start[i] && s < tab_end[i] && tab_start[i] < e) begin
          lo = tab_off[i];
          hi = tab_off[i] + OffW'(tab_size[i]);
          k = lo_q.size();
          while (k > 0 && (lo_q[k-1] > lo || (lo_q[k-1] == lo && hi_q[k-1] > hi))) k--;
          lo_q.insert(k, lo);
          hi_q.insert(k, hi);
        end
      end
      for (int i = 0; i < lo_q.size(); i++) begin
        if (lo_q[i] >= cand && lo_q[i] - cand >= OffW'(sz)) break;
        if (hi_q[i] > cand) cand = hi_q[i];
      end
      return cand;
    endfunction

    function void note_item(in_t it);
      out_t r;
      logic [OffW-1:0] top;
      if (it.new_frame) clear_table();
      r = '0;
      if (count >= Depth) begin
        r.peak = frame_peak;
        r.table_full = 1'b1;
      end else begin
        r.offset = first_fit(it.life_start, it.life_end, it.alloc_size);
        tab_start[count] = it.life_start;
        tab_end[count] = it.life_end;
        tab_off[count] = r.offset;
        tab_size[count] = it.alloc_size;
        count++;
        top = r.offset + OffW'(it.alloc_size);
        if (top > frame_peak) frame_peak = top;
        r.peak = frame_peak;
      end
      pending = {pending, r};
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.offset !== exp_r.offset) begin
        $display("%0t: offset expected %0d actual %0d", $realtime, exp_r.offset, got.offset);
        errors++;
      end
      if (got.peak !== exp_r.peak) begin
        $display("%0t: peak expected %0d actual %0d", $realtime, exp_r.peak, got.peak);
        errors++;
      end
      if (got.table_full !== exp_r.table_full) begin
        $display("%0t: table_full expected %0b actual %0b", $realtime, exp_r.table_full,
                 got.table_full);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  in_t  item_i;
  logic busy;
  out_t result_o;
  logic result_valid_o;

  placement_board board;
  int unsigned idle_pct;
  int unsigned quiet_cycles;
  int unsigned frame_len;

  lifetime_aware_first_fit_placer_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .result_o(result_o), .result_valid_o(result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result(result_o);
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_item(bit nf);
    in_t it;
    it.new_frame = nf;
    if ($urandom_range(9) < 8) begin
      it.life_start = $urandom_range(30);
      it.life_end = it.life_start + $urandom_range(1, 12);
      it.alloc_size = ($urandom_range(3) == 0) ? $urandom : $urandom_range(64);
      if ($urandom_range(19) == 0) it.alloc_size = 0;
    end else begin
      it.life_start = edge_word();
      it.life_end = edge_word();
      it.alloc_size = edge_word();
    end
    return it;
  endfunction

  function automatic in_t mk(bit nf, logic [31:0] s, logic [31:0] e, logic [31:0] sz);
    in_t it;
    it.new_frame = nf;
    it.life_start = s;
    it.life_end = e;
    it.alloc_size = sz;
    return it;
  endfunction

  initial begin
    board = new();
    board.clear_table();
    board.errors = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(mk(1, 0, 10, 16));
    send_item(mk(0, 5, 15, 8));
    send_item(mk(0, 20, 30, 4));
    send_item(mk(0, 0, 30, 0));
    send_item(mk(0, 8, 3, 100));
    send_item(mk(0, 7, 7, 5));
    send_item(mk(0, 0, 32'hffff_ffff, 32'hffff_ffff));
    send_item(mk(0, 32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff));
    send_item(mk(0, 2, 12, 16));
    send_item(mk(1, 0, 4, 10));
    send_item(mk(0, 0, 4, 2));
    send_item(mk(0, 0, 4, 3));
    drain();
    for (int i = 0; i < Depth + 3; i++) send_item(mk(i == 0, i % 7, i % 7 + 3, 32'hffff_ffff));
    send_item(mk(1, 1, 5, 9));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 64 : (ph == 3 ? 19 : 0);
      for (int n = 0; n < 500; n++) begin
        frame_len = $urandom_range(0, 99);
        send_item(rand_item(frame_len < 3));
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### lifetime_aware_first_fit_placer_unit.f
hw/rtl/lafp_pkg.sv
hw/rtl/lafp_ram.sv
hw/rtl/lifetime_aware_first_fit_placer_unit.sv
tb/lifetime_aware_first_fit_placer_unit_tb.sv
